FILE: rtl/pcs_pkg.sv
`timescale 1ns / 1ps

package pcs_pkg;

    localparam int NUM_COUNTERS_DEF = 4;
    localparam int COUNT_WIDTH_DEF  = 32;
    localparam int IN_READINGS      = 4;
    localparam int MAX_RESULTS      = 4;
    localparam int FIELD_WIDTH      = 32;
    localparam int RUN_WIDTH        = 32;
    localparam int SUM_WIDTH        = 64;

    typedef enum logic [1:0] {
        REQ_RESET = 2'd0,
        REQ_START = 2'd1,
        REQ_PAUSE = 2'd2,
        REQ_STOP  = 2'd3
    } req_code_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FOLD,
        ST_DIVIDE,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic [1:0]             req_type;
        logic [FIELD_WIDTH-1:0] load_store_count;
        logic [FIELD_WIDTH-1:0] miss_cycle_count;
        logic [FIELD_WIDTH-1:0] cycle_count;
        logic [FIELD_WIDTH-1:0] instruction_count;
    } req_item_t;

    typedef struct packed {
        logic [1:0]             counter_index;
        logic [FIELD_WIDTH-1:0] last_value;
        logic [FIELD_WIDTH-1:0] peak_value;
        logic [FIELD_WIDTH-1:0] average_value;
        logic [RUN_WIDTH-1:0]   run_count;
        logic                   last_of_run;
    } res_item_t;

    // Commands from the sequencer to the counter bank.
    typedef struct packed {
        logic clear_all;
        logic take_snapshot;
        logic add_deltas;
        logic set_paused;
        logic count_stop;
        logic fold;
        logic clear_acc;
    } bank_ctrl_t;

endpackage

FILE: rtl/pcs_divider.sv
`timescale 1ns / 1ps

module pcs_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pcs_pkg::SUM_WIDTH-1:0] dividend,
    input  logic [pcs_pkg::RUN_WIDTH-1:0] divisor,
    output logic                          done,
    output logic [pcs_pkg::SUM_WIDTH-1:0] quotient
);
    import pcs_pkg::*;

    localparam int CNT_W = $clog2(SUM_WIDTH + 1);

    logic [RUN_WIDTH-1:0] rem_reg;
    logic [RUN_WIDTH-1:0] rem_next;
    logic [SUM_WIDTH-1:0] quo_reg;
    logic [RUN_WIDTH-1:0] divisor_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [RUN_WIDTH:0]   trial;
    logic                 fits;

    // Restoring division, one quotient bit per cycle. The dividend shifts out
    // of the top of the quotient register while quotient bits enter below.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[SUM_WIDTH-1]};
        fits     = (trial >= {1'b0, divisor_reg});
        rem_next = fits ? RUN_WIDTH'(trial - {1'b0, divisor_reg})
                        : trial[RUN_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SUM_WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[SUM_WIDTH-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/pcs_bank.sv
`timescale 1ns / 1ps

module pcs_bank #(
    parameter int NUM_COUNTERS = pcs_pkg::NUM_COUNTERS_DEF,
    parameter int COUNT_WIDTH  = pcs_pkg::COUNT_WIDTH_DEF,
    parameter int IDX_W        = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pcs_pkg::bank_ctrl_t           ctrl,
    input  logic [IDX_W-1:0]              idx,
    input  pcs_pkg::req_item_t            req,
    output logic [COUNT_WIDTH-1:0]        acc_sel,
    output logic [COUNT_WIDTH-1:0]        peak_sel,
    output logic [pcs_pkg::SUM_WIDTH-1:0] fold_sum,
    output logic [pcs_pkg::RUN_WIDTH-1:0] stop_count,
    output logic                          paused
);
    import pcs_pkg::*;

    logic [COUNT_WIDTH-1:0] acc_reg  [NUM_COUNTERS];
    logic [COUNT_WIDTH-1:0] snap_reg [NUM_COUNTERS];
    logic [SUM_WIDTH-1:0]   sum_reg  [NUM_COUNTERS];
    logic [COUNT_WIDTH-1:0] peak_reg [NUM_COUNTERS];
    logic [RUN_WIDTH-1:0]   stop_reg;
    logic                   paused_reg;

    logic [FIELD_WIDTH-1:0] words [IN_READINGS];
    logic [COUNT_WIDTH-1:0] rd    [NUM_COUNTERS];
    logic [SUM_WIDTH:0]     sum_wide;

    // Counters past the four input readings see a constant zero reading.
    always_comb
    begin
        words[0] = req.load_store_count;
        words[1] = req.miss_cycle_count;
        words[2] = req.cycle_count;
        words[3] = req.instruction_count;
        for (int i = 0; i < NUM_COUNTERS; i++)
        begin
            rd[i] = (i < IN_READINGS) ? COUNT_WIDTH'(words[i % IN_READINGS]) : '0;
        end
    end

    always_comb
    begin
        sum_wide = {1'b0, sum_reg[idx]} + (SUM_WIDTH + 1)'(acc_reg[idx]);
        fold_sum = sum_wide[SUM_WIDTH] ? '1 : sum_wide[SUM_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                acc_reg[i]  <= '0;
                snap_reg[i] <= '0;
                sum_reg[i]  <= '0;
                peak_reg[i] <= '0;
            end
            stop_reg   <= '0;
            paused_reg <= 1'b1;
        end
        else if (ctrl.clear_all)
        begin
            // The start snapshot survives a reset command.
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                acc_reg[i]  <= '0;
                sum_reg[i]  <= '0;
                peak_reg[i] <= '0;
            end
            stop_reg   <= '0;
            paused_reg <= 1'b1;
        end
        else
        begin
            if (ctrl.take_snapshot)
            begin
                for (int i = 0; i < NUM_COUNTERS; i++)
                begin
                    snap_reg[i] <= rd[i];
                end
                paused_reg <= 1'b0;
            end
            if (ctrl.add_deltas)
            begin
                for (int i = 0; i < NUM_COUNTERS; i++)
                begin
                    acc_reg[i] <= acc_reg[i] + (rd[i] - snap_reg[i]);
                end
            end
            if (ctrl.set_paused)
            begin
                paused_reg <= 1'b1;
            end
            if (ctrl.count_stop && (stop_reg != '1))
            begin
                stop_reg <= stop_reg + RUN_WIDTH'(1);
            end
            if (ctrl.fold)
            begin
                sum_reg[idx] <= fold_sum;
                if (acc_reg[idx] > peak_reg[idx])
                begin
                    peak_reg[idx] <= acc_reg[idx];
                end
            end
            if (ctrl.clear_acc)
            begin
                acc_reg[idx] <= '0;
            end
        end
    end

    assign acc_sel    = acc_reg[idx];
    assign peak_sel   = peak_reg[idx];
    assign stop_count = stop_reg;
    assign paused     = paused_reg;

endmodule

FILE: rtl/profile_counter_statistics_core.sv
`timescale 1ns / 1ps

// Profiling statistics over a set of free-running event counters.
// The request channel (req_valid, req_stall, req) carries a command and the
// present readings of the load/store, miss-cycle, cycle and instruction
// counters. Reset, start and pause requests are taken while idle and give
// no result. A stop request gives one result per counter, up to four, on the
// result channel (res_valid, res_stall, res), the last one flagged by
// last_of_run.
// Each result first folds the run total into the sum and peak and then uses
// one shared 64-by-32 restoring divider for the average, one quotient bit per
// cycle. Counters past the reported ones are folded too, without a result.
// req_stall is high while a stop is in progress, until its last result is
// taken and any further counters are folded. When the receiver stalls, the
// result is held in the output register and the sequencer waits. After reset
// the block is idle, all accumulators, sums, peaks and the run count are
// zero, and the block is paused.
module profile_counter_statistics_core #(
    parameter int NUM_COUNTERS = pcs_pkg::NUM_COUNTERS_DEF,
    parameter int COUNT_WIDTH  = pcs_pkg::COUNT_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  pcs_pkg::req_item_t req,
    output logic               res_valid,
    input  logic               res_stall,
    output pcs_pkg::res_item_t res
);
    import pcs_pkg::*;

    localparam int IDX_W       = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
    localparam int NUM_RESULTS = (NUM_COUNTERS < MAX_RESULTS) ? NUM_COUNTERS : MAX_RESULTS;
    localparam logic [IDX_W:0]   NRES_L  = (IDX_W + 1)'(NUM_RESULTS);
    localparam logic [IDX_W-1:0] LAST_L  = IDX_W'(NUM_COUNTERS - 1);
    localparam logic [IDX_W-1:0] LASTR_L = IDX_W'(NUM_RESULTS - 1);

    seq_state_t state_reg;
    seq_state_t state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    res_item_t  res_reg;
    res_item_t  res_next;
    logic       res_valid_reg;

    bank_ctrl_t ctrl;
    logic       div_start;
    logic       load_res;
    logic       emit;
    logic       idx_last;
    logic       res_taken;

    logic [COUNT_WIDTH-1:0] acc_sel;
    logic [COUNT_WIDTH-1:0] peak_sel;
    logic [SUM_WIDTH-1:0]   fold_sum;
    logic [RUN_WIDTH-1:0]   stop_count;
    logic                   paused;
    logic                   div_done;
    logic [SUM_WIDTH-1:0]   quotient;
    logic [COUNT_WIDTH-1:0] avg_sat;

    pcs_bank #(
        .NUM_COUNTERS (NUM_COUNTERS),
        .COUNT_WIDTH  (COUNT_WIDTH),
        .IDX_W        (IDX_W)
    ) u_bank (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .idx        (idx_reg),
        .req        (req),
        .acc_sel    (acc_sel),
        .peak_sel   (peak_sel),
        .fold_sum   (fold_sum),
        .stop_count (stop_count),
        .paused     (paused)
    );

    pcs_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (fold_sum),
        .divisor  (stop_count),
        .done     (div_done),
        .quotient (quotient)
    );

    assign emit      = ({1'b0, idx_reg} < NRES_L);
    assign idx_last  = (idx_reg == LAST_L);
    assign res_taken = res_valid_reg && !res_stall;
    assign req_stall = (state_reg != ST_IDLE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && (req.req_type == REQ_STOP))
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (emit)
                begin
                    state_next = ST_DIVIDE;
                end
                else if (idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (res_taken)
                begin
                    state_next = idx_last ? ST_IDLE : ST_FOLD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb
    begin
        ctrl      = '0;
        div_start = 1'b0;
        load_res  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req.req_type)
                        REQ_RESET: ctrl.clear_all = 1'b1;
                        REQ_START: ctrl.take_snapshot = 1'b1;
                        REQ_PAUSE:
                        begin
                            ctrl.add_deltas = 1'b1;
                            ctrl.set_paused = 1'b1;
                        end
                        REQ_STOP:
                        begin
                            ctrl.add_deltas = !paused;
                            ctrl.set_paused = 1'b1;
                            ctrl.count_stop = 1'b1;
                        end
                        default: ctrl = '0;
                    endcase
                end
            end
            ST_FOLD:
            begin
                ctrl.fold      = 1'b1;
                div_start      = emit;
                ctrl.clear_acc = !emit;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    ctrl.clear_acc = 1'b1;
                    load_res       = 1'b1;
                end
            end
            ST_EMIT:
            begin
                ctrl = '0;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (state_reg == ST_IDLE)
        begin
            idx_next = '0;
        end
        else if (((state_reg == ST_FOLD) && !emit && !idx_last)
                 || ((state_reg == ST_EMIT) && res_taken && !idx_last))
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        avg_sat = (|quotient[SUM_WIDTH-1:COUNT_WIDTH]) ? '1 : quotient[COUNT_WIDTH-1:0];
        res_next.counter_index = 2'(idx_reg);
        res_next.last_value    = FIELD_WIDTH'(acc_sel);
        res_next.peak_value    = FIELD_WIDTH'(peak_sel);
        res_next.average_value = FIELD_WIDTH'(avg_sat);
        res_next.run_count     = stop_count;
        res_next.last_of_run   = (idx_reg == LASTR_L);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            priority if (load_res)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_taken)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: tb/profile_stats_checker.sv
`timescale 1ns / 1ps

module profile_stats_checker
    import pcs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_stall,
    input  req_item_t req,
    input  logic      res_valid,
    input  logic      res_stall,
    input  res_item_t res,
    output int        fail_count,
    output int        backlog
);

    localparam int NCNT = NUM_COUNTERS_DEF;

    logic [31:0] run_total [NCNT];
    logic [31:0] snapshot  [NCNT];
    logic [63:0] total_sum [NCNT];
    logic [31:0] best_run  [NCNT];
    logic [31:0] stops;
    logic        halted;

    res_item_t   stats_due [$];

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Advances the profile state by one request and queues the statistics
    // that a stop reports.
    task automatic advance_profile(input req_item_t r);
        logic [31:0] reading [NCNT];
        logic [63:0] s;
        logic [63:0] avg;
        res_item_t   e;
        int          i;
        reading[0] = r.load_store_count;
        reading[1] = r.miss_cycle_count;
        reading[2] = r.cycle_count;
        reading[3] = r.instruction_count;
        case (r.req_type)
            REQ_RESET:
            begin
                for (i = 0; i < NCNT; i++)
                begin
                    run_total[i] = '0;
                    total_sum[i] = '0;
                    best_run[i]  = '0;
                end
                stops  = '0;
                halted = 1'b1;
            end
            REQ_START:
            begin
                for (i = 0; i < NCNT; i++)
                    snapshot[i] = reading[i];
                halted = 1'b0;
            end
            REQ_PAUSE:
            begin
                // A pause while paused still adds the interval again.
                for (i = 0; i < NCNT; i++)
                    run_total[i] = run_total[i] + (reading[i] - snapshot[i]);
                halted = 1'b1;
            end
            default:
            begin
                if (!halted)
                begin
                    for (i = 0; i < NCNT; i++)
                        run_total[i] = run_total[i] + (reading[i] - snapshot[i]);
                    halted = 1'b1;
                end
                if (stops != 32'hFFFF_FFFF)
                    stops = stops + 32'd1;
                for (i = 0; i < NCNT; i++)
                begin
                    s = total_sum[i] + {32'd0, run_total[i]};
                    if (s < total_sum[i])
                        s = '1;
                    total_sum[i] = s;
                    if (run_total[i] > best_run[i])
                        best_run[i] = run_total[i];
                    avg = s / {32'd0, stops};
                    if (avg > 64'hFFFF_FFFF)
                        avg = 64'hFFFF_FFFF;
                    e.counter_index = i[1:0];
                    e.last_value    = run_total[i];
                    e.peak_value    = best_run[i];
                    e.average_value = avg[31:0];
                    e.run_count     = stops;
                    e.last_of_run   = (i == NCNT - 1);
                    stats_due.push_back(e);
                    run_total[i] = '0;
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NCNT; i++)
            begin
                run_total[i] = '0;
                snapshot[i]  = '0;
                total_sum[i] = '0;
                best_run[i]  = '0;
            end
            stops  = '0;
            halted = 1'b1;
            stats_due.delete();
            fail_count = 0;
            backlog <= 0;
        end
        else
        begin
            // Results belong to earlier stops, so they are matched first.
            if (res_valid && !res_stall)
            begin
                if (stats_due.size() == 0)
                begin
                    $error("unexpected result: counter_index %0d, last_value %0h",
                           res.counter_index, res.last_value);
                    fail_count++;
                end
                else
                begin
                    want = stats_due.pop_front();
                    check_field("counter_index", want.counter_index, res.counter_index);
                    check_field("last_value", want.last_value, res.last_value);
                    check_field("peak_value", want.peak_value, res.peak_value);
                    check_field("average_value", want.average_value, res.average_value);
                    check_field("run_count", want.run_count, res.run_count);
                    check_field("last_of_run", want.last_of_run, res.last_of_run);
                end
            end
            if (req_valid && !req_stall)
                advance_profile(req);
            backlog <= stats_due.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pcs_pkg::*;

    localparam int TOTAL_ITEMS = 400;
    localparam int QUIET_FROM  = 340;
    localparam int CYCLE_LIMIT = 800_000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res;

    int        fail_count;
    int        backlog;
    int        sent = 0;
    int        cycles = 0;
    int        stall_left = 0;
    bit        quiet = 1'b0;
    logic [31:0] now_count [4];

    profile_counter_statistics_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    profile_stats_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .fail_count (fail_count),
        .backlog    (backlog)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver holds off in short random bursts.
    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (!quiet && $urandom_range(0, 4) == 0)
        begin
            res_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end
        else
            res_stall <= 1'b0;
    end

    function automatic req_item_t make_req(input req_code_t code, input logic [31:0] a,
                                           input logic [31:0] b, input logic [31:0] c,
                                           input logic [31:0] d);
        req_item_t r;
        r.req_type          = code;
        r.load_store_count  = a;
        r.miss_cycle_count  = b;
        r.cycle_count       = c;
        r.instruction_count = d;
        return r;
    endfunction

    task automatic send_request(input req_item_t item);
        int n;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 4);
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sent++;
        quiet = (sent >= QUIET_FROM);
    endtask

    task automatic send_all(input req_code_t code, input logic [31:0] v);
        send_request(make_req(code, v, v, v, v));
    endtask

    // Moves the free-running readings forward; large strides make them wrap.
    task automatic tick_counters();
        for (int i = 0; i < 4; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: now_count[i] = now_count[i] + $urandom_range(0, 1000);
                6, 7:             now_count[i] = now_count[i] + $urandom_range(0, 1 << 20);
                8:                now_count[i] = now_count[i] + $urandom;
                default:          ;
            endcase
        end
    endtask

    task automatic send_now(input req_code_t code);
        tick_counters();
        send_request(make_req(code, now_count[0], now_count[1], now_count[2],
                              now_count[3]));
    endtask

    task automatic run_session();
        int steps;
        send_now(REQ_START);
        steps = $urandom_range(0, 3);
        repeat (steps)
        begin
            case ($urandom_range(0, 3))
                0: send_now(REQ_PAUSE);
                1:
                begin
                    send_now(REQ_PAUSE);
                    send_now(REQ_START);
                end
                2: send_now(REQ_START);
                default: send_now(REQ_PAUSE);
            endcase
        end
        send_now(REQ_STOP);
    endtask

    initial
    begin
        for (int i = 0; i < 4; i++)
            now_count[i] = $urandom;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Stop straight after reset reports an empty run.
        send_all(REQ_STOP, 32'h0);
        // Readings that wrap between start and stop.
        send_all(REQ_START, 32'hFFFF_FFFF);
        send_all(REQ_STOP, 32'h0000_0005);
        // Repeated pause counts the same interval twice; the stop that
        // follows while paused adds nothing.
        send_all(REQ_START, 32'h0);
        send_all(REQ_PAUSE, 32'hFFFF_FFFF);
        send_all(REQ_PAUSE, 32'hFFFF_FFFF);
        send_all(REQ_STOP, 32'h1234_5678);
        // Start while running retakes the snapshot.
        send_all(REQ_START, 32'd100);
        send_all(REQ_START, 32'd200);
        send_all(REQ_STOP, 32'd250);
        // Reset command clears the statistics but keeps the snapshot.
        send_all(REQ_RESET, 32'hFFFF_FFFF);
        send_all(REQ_STOP, 32'h0);
        send_request(make_req(REQ_START, 32'hAAAA_AAAA, 32'h5555_5555,
                              32'hAAAA_AAAA, 32'h5555_5555));
        send_request(make_req(REQ_STOP, 32'h5555_5555, 32'hAAAA_AAAA,
                              32'h5555_5555, 32'hAAAA_AAAA));
        send_all(REQ_START, 32'd10);
        send_all(REQ_PAUSE, 32'd20);
        send_all(REQ_START, 32'd1000);
        send_all(REQ_PAUSE, 32'd1003);
        send_all(REQ_STOP, 32'd5000);

        while (sent < TOTAL_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0: send_now(REQ_RESET);
                1, 2:
                    send_request(make_req(req_code_t'($urandom_range(0, 3)), $urandom,
                                          $urandom, $urandom, $urandom));
                default: run_session();
            endcase
        end
        req_valid <= 1'b0;

        // The backlog count is registered in the checker and settles after the last request.
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0 && backlog == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
